>>> sv/glcd_pkg.sv
package glcd_pkg;

  // Display geometry. A page is eight pixel rows; each half has its own controller.
  localparam int PAGE_COUNT   = 8;
  localparam int HALF_COLUMNS = 64;

  localparam int BUF_DEPTH  = 1024;
  localparam int BUF_ADDR_W = 10;
  localparam int PAGE_W     = 3;
  localparam int COL_W      = 6;

  // Request codes.
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_REFRESH = 2'd2;

  // Chip select codes.
  localparam logic [1:0] CS_LEFT  = 2'd1;
  localparam logic [1:0] CS_RIGHT = 2'd2;
  localparam logic [1:0] CS_BOTH  = 2'd3;

  // Controller commands.
  localparam logic [7:0] CMD_SET_PAGE = 8'hB8;
  localparam logic [7:0] CMD_SET_COL0 = 8'h40;

  // Job queue between the front and back parts.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PAGE,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [BUF_ADDR_W-1:0] buf_addr;
    logic [7:0]            buf_byte;
  } req_t;

  typedef struct packed {
    logic       is_data;
    logic [1:0] chip_select;
    logic [7:0] bus_byte;
    logic       last;
  } bus_t;

  typedef struct packed {
    logic              is_data;
    logic [PAGE_W-1:0] page;
    logic [7:0]        left;
    logic [7:0]        right;
  } job_t;

  typedef struct packed {
    logic                  we;
    logic [BUF_ADDR_W-1:0] waddr;
    logic [7:0]            wdata;
    logic                  re;
    logic [BUF_ADDR_W-1:0] raddr_l;
    logic [BUF_ADDR_W-1:0] raddr_r;
  } mem_ctl_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

>>> sv/glcd_frame_refresh_sequencer.sv
// Frame refresh sequencer for a 128x64 graphic display split into two
// 64-column controller halves. Request items write one byte of the
// 1024-byte frame buffer (page times 128 plus column), start a refresh, or
// advance the refresh by one tick. A page-start tick produces three command
// bus items to both halves (set page, set column 0, set page), a data tick
// produces a left-half and then a right-half pixel byte, and the final item
// of each tick carries last. After reset the frame buffer is zeroed by a
// clearing pass, during which req_stall stays high. After that, one request
// item is accepted per cycle as long as the four-entry job queue has room.
// The bus side delivers one item per cycle while bus_stall is low, and that
// output port sets the sustained rate of a refresh. On its way to the bus
// a tick passes the read stage, the job queue and then the output register.
module glcd_frame_refresh_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  glcd_pkg::req_t req,
  output logic           bus_valid,
  input  logic           bus_stall,
  output glcd_pkg::bus_t bus
);

  glcd_pkg::mem_ctl_t              mem_ctl;
  logic [7:0]                      rdata_l;
  logic [7:0]                      rdata_r;
  logic                            push;
  glcd_pkg::job_t                  push_job;
  logic                            pop;
  glcd_pkg::head_t                 head;
  logic [glcd_pkg::FIFO_CNT_W-1:0] fifo_count;

  // The front part runs the phase machine, owns the buffer write port and
  // reads both halves' bytes at the moment a data tick is accepted, so a
  // later buffer write cannot alter bytes already scheduled for the bus.
  glcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .fifo_count (fifo_count),
    .rdata_l    (rdata_l),
    .rdata_r    (rdata_r),
    .mem        (mem_ctl),
    .push       (push),
    .push_job   (push_job)
  );

  glcd_fb_mem u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rdata_l (rdata_l),
    .rdata_r (rdata_r)
  );

  // Jobs wait here while the bus side is stalled.
  glcd_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .count    (fifo_count)
  );

  // The back part expands each job into its bus items.
  glcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .bus_valid (bus_valid),
    .bus_stall (bus_stall),
    .bus       (bus)
  );

endmodule

>>> sv/glcd_fb_mem.sv
module glcd_fb_mem (
  input  logic               clk,
  input  glcd_pkg::mem_ctl_t ctl,
  output logic [7:0]         rdata_l,
  output logic [7:0]         rdata_r
);

  logic [7:0] mem [glcd_pkg::BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rdata_l <= mem[ctl.raddr_l];
      rdata_r <= mem[ctl.raddr_r];
    end
  end

endmodule

>>> sv/glcd_front.sv
module glcd_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  glcd_pkg::req_t                  req,
  input  logic [glcd_pkg::FIFO_CNT_W-1:0] fifo_count,
  input  logic [7:0]                      rdata_l,
  input  logic [7:0]                      rdata_r,
  output glcd_pkg::mem_ctl_t              mem,
  output logic                            push,
  output glcd_pkg::job_t                  push_job
);

  glcd_pkg::phase_t                phase, phase_next;
  logic [glcd_pkg::PAGE_W-1:0]     page, page_next;
  logic [glcd_pkg::COL_W-1:0]      col, col_next;
  logic                            clearing;
  logic [glcd_pkg::BUF_ADDR_W-1:0] clr_addr;
  logic                            s1_valid, s1_valid_next;
  logic                            s1_is_data, s1_is_data_next;
  logic [glcd_pkg::PAGE_W-1:0]     s1_page, s1_page_next;
  logic                            accept;

  // Room is reserved for the job still in the read stage, so a push never fails.
  assign req_stall = clearing ||
                     ((int'(fifo_count) + int'(s1_valid)) >= glcd_pkg::FIFO_DEPTH);
  assign accept    = req_valid && !req_stall;

  assign push     = s1_valid;
  assign push_job = '{is_data: s1_is_data, page: s1_page, left: rdata_l, right: rdata_r};

  always_comb begin
    phase_next      = phase;
    page_next       = page;
    col_next        = col;
    s1_valid_next   = 1'b0;
    s1_is_data_next = s1_is_data;
    s1_page_next    = s1_page;
    mem.we          = clearing;
    mem.waddr       = clr_addr;
    mem.wdata       = 8'd0;
    mem.re          = 1'b0;
    mem.raddr_l     = {page, 1'b0, col};
    mem.raddr_r     = {page, 1'b1, col};
    if (accept) begin
      case (req.req_type)
        glcd_pkg::REQ_WRITE: begin
          mem.we    = 1'b1;
          mem.waddr = req.buf_addr;
          mem.wdata = req.buf_byte;
        end
        glcd_pkg::REQ_REFRESH: begin
          page_next  = '0;
          col_next   = '0;
          phase_next = glcd_pkg::PH_PAGE;
        end
        glcd_pkg::REQ_TICK: begin
          case (phase)
            glcd_pkg::PH_PAGE: begin
              s1_valid_next   = 1'b1;
              s1_is_data_next = 1'b0;
              s1_page_next    = page;
              phase_next      = glcd_pkg::PH_DATA;
            end
            glcd_pkg::PH_DATA: begin
              mem.re          = 1'b1;
              s1_valid_next   = 1'b1;
              s1_is_data_next = 1'b1;
              s1_page_next    = page;
              if (int'(col) >= glcd_pkg::HALF_COLUMNS - 1) begin
                col_next = '0;
                if (int'(page) >= glcd_pkg::PAGE_COUNT - 1) begin
                  page_next  = '0;
                  phase_next = glcd_pkg::PH_DONE;
                end else begin
                  page_next  = page + 1'b1;
                  phase_next = glcd_pkg::PH_PAGE;
                end
              end else begin
                col_next = col + 1'b1;
              end
            end
            glcd_pkg::PH_DONE: begin
              page_next  = '0;
              col_next   = '0;
              phase_next = glcd_pkg::PH_IDLE;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= glcd_pkg::PH_IDLE;
      page     <= '0;
      col      <= '0;
      clearing <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
    end else begin
      phase    <= phase_next;
      page     <= page_next;
      col      <= col_next;
      s1_valid <= s1_valid_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == glcd_pkg::BUF_ADDR_W'(glcd_pkg::BUF_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_is_data <= s1_is_data_next;
    s1_page    <= s1_page_next;
  end

endmodule

>>> sv/glcd_job_fifo.sv
module glcd_job_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  glcd_pkg::job_t                  push_job,
  input  logic                            pop,
  output glcd_pkg::head_t                 head,
  output logic [glcd_pkg::FIFO_CNT_W-1:0] count
);

  glcd_pkg::job_t                  entries [glcd_pkg::FIFO_DEPTH];
  logic [glcd_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [glcd_pkg::FIFO_PTR_W-1:0] rd_ptr;

  assign head.valid = (count != '0);
  assign head.job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

>>> sv/glcd_back.sv
module glcd_back (
  input  logic            clk,
  input  logic            rst,
  input  glcd_pkg::head_t head,
  output logic            pop,
  output logic            bus_valid,
  input  logic            bus_stall,
  output glcd_pkg::bus_t  bus
);

  logic [1:0]     sub, sub_next;
  logic           load;
  logic           is_last;
  logic [7:0]     page_cmd;
  glcd_pkg::bus_t item;

  assign load     = head.valid && (!bus_valid || !bus_stall);
  assign page_cmd = glcd_pkg::CMD_SET_PAGE + {5'd0, head.job.page};

  // A data job expands to left then right byte; a page job to three commands.
  always_comb begin
    if (head.job.is_data) begin
      is_last          = (sub != 2'd0);
      item.is_data     = 1'b1;
      item.chip_select = is_last ? glcd_pkg::CS_RIGHT : glcd_pkg::CS_LEFT;
      item.bus_byte    = is_last ? head.job.right : head.job.left;
    end else begin
      is_last          = (sub == 2'd2);
      item.is_data     = 1'b0;
      item.chip_select = glcd_pkg::CS_BOTH;
      item.bus_byte    = (sub == 2'd1) ? glcd_pkg::CMD_SET_COL0 : page_cmd;
    end
    item.last = is_last;
    pop       = load && is_last;
    sub_next  = sub;
    if (load) begin
      sub_next = is_last ? 2'd0 : sub + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_valid <= 1'b0;
      sub       <= 2'd0;
    end else begin
      bus_valid <= load || (bus_valid && bus_stall);
      sub       <= sub_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bus <= item;
    end
  end

endmodule

>>> sv/glcd_checker.sv
module glcd_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_stall,
  input logic           bus_valid,
  input logic           bus_stall,
  input glcd_pkg::bus_t bus
);

  // The buffer clearing pass keeps requests out right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request accepted during buffer clearing");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    bus_valid && bus_stall |=> bus_valid && $stable(bus))
    else $error("stalled bus item changed");

  a_cmd_both: assert property (@(posedge clk) disable iff (rst)
    bus_valid && !bus.is_data |-> bus.chip_select == glcd_pkg::CS_BOTH)
    else $error("command not sent to both halves");

  a_data_pair: assert property (@(posedge clk) disable iff (rst)
    bus_valid && bus.is_data |->
      (bus.chip_select == glcd_pkg::CS_LEFT && !bus.last) ||
      (bus.chip_select == glcd_pkg::CS_RIGHT && bus.last))
    else $error("data item has wrong half or last flag");

  a_right_follows: assert property (@(posedge clk) disable iff (rst)
    bus_valid && !bus_stall && bus.is_data && bus.chip_select == glcd_pkg::CS_LEFT |=>
      bus_valid && bus.is_data && bus.chip_select == glcd_pkg::CS_RIGHT)
    else $error("right-half byte did not follow left-half byte");

endmodule

bind glcd_frame_refresh_sequencer glcd_checker u_glcd_checker (.*);

>>> sim/glcd_frame_refresh_sequencer_tb.sv
module glcd_frame_refresh_sequencer_tb;
  import glcd_pkg::*;

  // The package names only the three request codes that do something. The
  // fourth code must be ignored by the block, so it gets a name here.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Length of the one long receiver hold-off. It is far longer than the job
  // queue can absorb, so the block has to stall its request side.
  localparam int HOLD_CYCLES = 400;
  // Quiet cycles after the last expected bus item. Any late extra item shows
  // up in this window.
  localparam int SETTLE_CYCLES = 32;
  // Random items sent after the full refresh pass. They mix refresh restarts,
  // ticks in idle, buffer writes and the unused code.
  localparam int NOISE_ITEMS = 60;
  // Number of random items spent in each idling mode; the last mode stays on.
  localparam int ITEMS_PER_MODE = 160;
  // Hard stop, as a simulation delay. A slow but correct run ends well before
  // it, including the buffer clear after reset.
  localparam int RUN_LIMIT = 3200000;

  // Mirror of the sequencer. It keeps its own frame buffer and phase
  // machine, and queues the bus items that each accepted request must cause.
  class glcd_refresh_scoreboard;
    logic [7:0]        pixels[BUF_DEPTH];
    phase_t            phase;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  column;
    bit                busy;
    bus_t              pending[$];
    int                errors;
    int                cmd_items;
    int                pixel_items;
    int                passes;

    function new();
      foreach (pixels[i]) pixels[i] = 8'h00;
      phase       = PH_IDLE;
      page        = '0;
      column      = '0;
      busy        = 1'b0;
      errors      = 0;
      cmd_items   = 0;
      pixel_items = 0;
      passes      = 0;
    endfunction

    function void push_bus(logic is_data, logic [1:0] cs, logic [7:0] value, logic last);
      bus_t item;
      item.is_data     = is_data;
      item.chip_select = cs;
      item.bus_byte    = value;
      item.last        = last;
      pending.push_back(item);
    endfunction

    function void note_request(req_t r);
      logic [7:0] page_cmd;
      page_cmd = CMD_SET_PAGE + {5'b0, page};
      case (r.req_type)
        REQ_WRITE: begin
          pixels[r.buf_addr] = r.buf_byte;
        end
        REQ_REFRESH: begin
          page   = '0;
          column = '0;
          phase  = PH_PAGE;
          busy   = 1'b1;
        end
        REQ_TICK: begin
          case (phase)
            PH_PAGE: begin
              push_bus(1'b0, CS_BOTH, page_cmd, 1'b0);
              push_bus(1'b0, CS_BOTH, CMD_SET_COL0, 1'b0);
              push_bus(1'b0, CS_BOTH, page_cmd, 1'b1);
              phase = PH_DATA;
            end
            PH_DATA: begin
              // Left byte sits at page*128+column, right byte 64 further on.
              push_bus(1'b1, CS_LEFT, pixels[{page, 1'b0, column}], 1'b0);
              push_bus(1'b1, CS_RIGHT, pixels[{page, 1'b1, column}], 1'b1);
              if (column == COL_W'(HALF_COLUMNS - 1)) begin
                column = '0;
                if (page == PAGE_W'(PAGE_COUNT - 1)) begin
                  page  = '0;
                  phase = PH_DONE;
                end else begin
                  page  = page + 1'b1;
                  phase = PH_PAGE;
                end
              end else begin
                column = column + 1'b1;
              end
            end
            PH_DONE: begin
              page   = '0;
              column = '0;
              phase  = PH_IDLE;
              busy   = 1'b0;
              passes++;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    endfunction

    function void check_bus(bus_t got);
      bus_t want;
      if (pending.size() == 0) begin
        $error("bus item with nothing expected: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.is_data) pixel_items++;
      else cmd_items++;
      if (got.is_data !== want.is_data) begin
        $error("is_data: expected %0d, got %0d", want.is_data, got.is_data);
        errors++;
      end
      if (got.chip_select !== want.chip_select) begin
        $error("chip_select: expected %0d, got %0d", want.chip_select, got.chip_select);
        errors++;
      end
      if (got.bus_byte !== want.bus_byte) begin
        $error("bus_byte: expected %02h, got %02h", want.bus_byte, got.bus_byte);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic bus_valid;
  logic bus_stall = 1'b0;
  bus_t bus;

  glcd_refresh_scoreboard frame_model;

  // Idling controls. The sender percentage is read only by the main process;
  // the receiver percentage and the hold request are handed to the receiver
  // process through nonblocking writes.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_pending  = 1'b0;
  bit hold_taken    = 1'b0;
  int hold_left     = 0;
  int items_sent    = 0;

  // Idling modes: none, sender mostly idle, receiver mostly stalling, both
  // idling a quarter of the time.
  int send_idle_tbl[4] = '{0, 83, 0, 25};
  int stall_tbl[4]     = '{0, 0, 83, 25};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  glcd_frame_refresh_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .bus_valid (bus_valid),
    .bus_stall (bus_stall),
    .bus       (bus)
  );

  // Receiver side. The long hold-off is counted here, in cycles, once the
  // main process asks for it; otherwise the stall is random.
  always @(posedge clk) begin
    if (hold_pending && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      bus_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      bus_stall <= 1'b1;
    end else begin
      bus_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every bus item taken at this edge is checked against the oldest
  // expectation. Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst && bus_valid && !bus_stall) begin
      frame_model.check_bus(bus);
    end
  end

  function automatic req_t make_request(logic [1:0] kind, logic [9:0] addr, logic [7:0] value);
    req_t r;
    r.req_type = kind;
    r.buf_addr = addr;
    r.buf_byte = value;
    return r;
  endfunction

  // Item inside a refresh pass: mostly ticks so the pass reaches its end,
  // some buffer writes that later ticks may read, and a little noise.
  function automatic req_t run_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 88) begin
      return make_request(REQ_TICK, 10'($urandom), 8'($urandom));
    end else if (pick < 98) begin
      return make_request(REQ_WRITE, 10'($urandom), 8'($urandom));
    end
    return make_request(REQ_UNUSED, 10'($urandom), 8'($urandom));
  endfunction

  // Item outside a full pass: restarts, ticks in every phase, writes and
  // the unused code all mixed together.
  function automatic req_t noise_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return make_request(REQ_WRITE, 10'($urandom), 8'($urandom));
    if (pick < 65) return make_request(REQ_TICK, 10'($urandom), 8'($urandom));
    if (pick < 80) return make_request(REQ_REFRESH, 10'($urandom), 8'($urandom));
    return make_request(REQ_UNUSED, 10'($urandom), 8'($urandom));
  endfunction

  // Offers one request item and returns at the edge where it is taken.
  // Random idle cycles come first; while offered, the payload stays put.
  task automatic send_request(input req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    frame_model.note_request(item);
    items_sent++;
  endtask

  task automatic set_idling(input int rand_idx);
    int mode;
    mode = rand_idx / ITEMS_PER_MODE;
    if (mode > 3) mode = 3;
    send_idle_pct = send_idle_tbl[mode];
    stall_pct    <= stall_tbl[mode];
  endtask

  initial begin
    int rand_idx;
    frame_model = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The request side stays stalled during the buffer
    // clear, so the first item simply waits for it.
    send_request(make_request(REQ_TICK, 10'h3FF, 8'hFF));     // tick while idle
    send_request(make_request(REQ_UNUSED, 10'h3FF, 8'hFF));   // unused code
    send_request(make_request(REQ_WRITE, 10'd0, 8'hFF));
    send_request(make_request(REQ_WRITE, 10'd1023, 8'hFF));
    send_request(make_request(REQ_WRITE, 10'd64, 8'hA5));
    send_request(make_request(REQ_WRITE, 10'd512, 8'h00));
    send_request(make_request(REQ_WRITE, 10'd63, 8'h5A));
    send_request(make_request(REQ_REFRESH, 10'd0, 8'h00));
    send_request(make_request(REQ_TICK, 10'd0, 8'h00));       // page start commands
    send_request(make_request(REQ_TICK, 10'd0, 8'h00));       // column 0, both halves
    // A write during the refresh must be seen by the next data tick.
    send_request(make_request(REQ_WRITE, 10'd1, 8'h81));
    send_request(make_request(REQ_TICK, 10'd0, 8'h00));
    send_request(make_request(REQ_UNUSED, 10'd0, 8'h00));     // ignored mid-pass
    send_request(make_request(REQ_TICK, 10'd0, 8'h00));
    // A refresh in the middle of a pass restarts at page 0.
    send_request(make_request(REQ_REFRESH, 10'd0, 8'h00));
    send_request(make_request(REQ_REFRESH, 10'd0, 8'h00));
    send_request(make_request(REQ_TICK, 10'd0, 8'h00));
    send_request(make_request(REQ_TICK, 10'd0, 8'h00));
    send_request(make_request(REQ_TICK, 10'd0, 8'h00));

    // Random part: one whole refresh pass through every page, the wrap to
    // the finish phase and back to idle, with writes interleaved. The
    // idling mode changes as the pass goes on.
    rand_idx = 0;
    set_idling(rand_idx);
    send_request(make_request(REQ_REFRESH, 10'($urandom), 8'($urandom)));
    rand_idx++;
    while (frame_model.busy) begin
      set_idling(rand_idx);
      // Once, hold the bus side off for a long time while requests keep
      // coming, so the job queue fills and req_stall has to rise.
      if (rand_idx == 60) hold_pending <= 1'b1;
      send_request(run_item());
      rand_idx++;
    end
    repeat (NOISE_ITEMS) begin
      set_idling(rand_idx);
      send_request(noise_item());
      rand_idx++;
    end
    req_valid <= 1'b0;
    stall_pct <= 0;

    while (frame_model.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d request items; checked %0d command and %0d pixel bus items.",
             items_sent, frame_model.cmd_items, frame_model.pixel_items);
    $display("Completed %0d full refresh passes across four idling modes.",
             frame_model.passes);
    if (frame_model.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("Some tests failed");
    $finish;
  end

endmodule
